// ===== rtl/ktcd_pkg.sv =====
// Shared types and constants of the keyed table with compacting delete.
package ktcd_pkg;

  localparam int unsigned ACT_W  = 3;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned PAY_W  = 64;
  localparam int unsigned POS_W  = 6;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_LOOKUP = 3'd1,
    ACT_UPDATE = 3'd2,
    ACT_DELETE = 3'd3,
    ACT_LIST   = 3'd4
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 3'd0,
    STAT_FULL  = 3'd1,
    STAT_DUP   = 3'd2,
    STAT_MISS  = 3'd3,
    STAT_EMPTY = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RESP,
    S_LIST_RD,
    S_LIST_EMIT,
    S_SHIFT_RD,
    S_SHIFT_WR
  } state_e;

  typedef struct packed {
    status_e                  status;
    logic signed [KEY_W-1:0]  key;
    logic [PAY_W-1:0]         payload;
    logic [POS_W-1:0]         position;
    logic                     last;
  } rsp_t;

  typedef struct packed {
    logic                     rd_en;
    logic [POS_W-1:0]         rd_addr;
    logic                     wr_en;
    logic [POS_W-1:0]         wr_addr;
    logic signed [KEY_W-1:0]  wr_key;
    logic [PAY_W-1:0]         wr_payload;
  } mem_cmd_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]  key;
    logic [PAY_W-1:0]         payload;
  } mem_rdata_t;

endpackage

// ===== rtl/ktcd_if.sv =====
// Request and result channel interfaces of the keyed table.
interface ktcd_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [ktcd_pkg::ACT_W-1:0]           action;
  logic signed [ktcd_pkg::KEY_W-1:0]    key;
  logic [ktcd_pkg::PAY_W-1:0]           payload;

  modport source (output valid, output action, output key, output payload, input ready);
  modport sink   (input valid, input action, input key, input payload, output ready);
endinterface

interface ktcd_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [ktcd_pkg::STAT_W-1:0]          status;
  logic signed [ktcd_pkg::KEY_W-1:0]    found_key;
  logic [ktcd_pkg::PAY_W-1:0]           found_payload;
  logic [ktcd_pkg::POS_W-1:0]           position;
  logic                                 last;

  modport source (output valid, output status, output found_key, output found_payload,
                  output position, output last, input ready);
  modport sink   (input valid, input status, input found_key, input found_payload,
                  input position, input last, output ready);
endinterface

// ===== rtl/keyed_table_compacting_delete_core.sv =====
// Top level of the keyed table with compacting delete.
//
//   channel  dir  handshake      payload
//   req_i    in   valid/ready    action, key, payload
//   rsp_o    out  valid/ready    status, found_key, found_payload, position, last
//
// One request at a time; req_i.ready is high only while no request is in progress.
// Insert, lookup, update: a scan of the entries, one registered memory read per entry.
// Delete then moves each later entry down one place, a read and a write per entry, and
// drops the count by one; list reads and then emits each entry in turn.
// Reset empties the table at once; entry memory needs no clearing.
// A stalled rsp_o holds one result in the output register and freezes the sequencer
// at its next result.
module keyed_table_compacting_delete_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ktcd_req_if.sink    req_i,
  ktcd_rsp_if.source  rsp_o
);
  import ktcd_pkg::*;

  mem_cmd_t   cmd;
  mem_rdata_t rdata;

  ktcd_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .rsp_o   (rsp_o),
    .cmd_o   (cmd),
    .rdata_i (rdata)
  );

  ktcd_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .rdata_o (rdata)
  );

endmodule

// ===== rtl/ktcd_store.sv =====
// Entry memory: key and payload words, one write port, one registered read port.
module ktcd_store #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                  clk_i,
  input  ktcd_pkg::mem_cmd_t    cmd_i,
  output ktcd_pkg::mem_rdata_t  rdata_o
);
  import ktcd_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic signed [KEY_W-1:0] key_mem [CAPACITY];
  logic [PAY_W-1:0]        pay_mem [CAPACITY];
  mem_rdata_t              rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      key_mem[cmd_i.wr_addr[AW-1:0]] <= cmd_i.wr_key;
      pay_mem[cmd_i.wr_addr[AW-1:0]] <= cmd_i.wr_payload;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q.key     <= key_mem[cmd_i.rd_addr[AW-1:0]];
      rdata_q.payload <= pay_mem[cmd_i.rd_addr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ktcd_ctrl.sv =====
// Request sequencer: key scan, append, update, compacting shift, list and result register.
module ktcd_ctrl #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ktcd_req_if.sink              req_i,
  ktcd_rsp_if.source            rsp_o,
  output ktcd_pkg::mem_cmd_t    cmd_o,
  input  ktcd_pkg::mem_rdata_t  rdata_i
);
  import ktcd_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e                  state_q, state_d;
  action_e                 act_q, act_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic [PAY_W-1:0]        pay_q, pay_d;
  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic                    pend_q, pend_d;
  logic [AW-1:0]           pend_idx_q, pend_idx_d;
  rsp_t                    res_q, res_d;
  logic                    out_vld_q, out_vld_d;
  rsp_t                    out_q, out_d;

  logic                    out_free;
  logic                    push;
  rsp_t                    push_rsp;
  logic                    found;
  logic                    issue;
  logic                    list_last;
  mem_cmd_t                cmd;

  assign out_free  = !out_vld_q || rsp_o.ready;
  assign found     = pend_q && (rdata_i.key == key_q);
  assign list_last = (idx_q + CW'(1)) == count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    key_q      <= key_d;
    pay_q      <= pay_d;
    idx_q      <= idx_d;
    pend_idx_q <= pend_idx_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  always_comb begin
    state_d    = state_q;
    act_d      = act_q;
    key_d      = key_q;
    pay_d      = pay_q;
    count_d    = count_q;
    idx_d      = idx_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    res_d      = res_q;
    push       = 1'b0;
    push_rsp   = res_q;
    issue      = 1'b0;
    cmd        = '0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          act_d = action_e'(req_i.action);
          key_d = req_i.key;
          pay_d = req_i.payload;
          idx_d = '0;
          res_d = '{status: STAT_EMPTY, key: '0, payload: '0, position: '0, last: 1'b1};
          case (req_i.action)
            ACT_INSERT: begin
              if (count_q == CW'(CAPACITY)) begin
                res_d.status = STAT_FULL;
                state_d      = S_RESP;
              end else begin
                state_d = S_SCAN;
              end
            end
            ACT_LOOKUP, ACT_UPDATE, ACT_DELETE: begin
              state_d = (count_q == '0) ? S_RESP : S_SCAN;
            end
            ACT_LIST: begin
              state_d = (count_q == '0) ? S_RESP : S_LIST_RD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_SCAN: begin
        issue       = !found && (idx_q != count_q);
        cmd.rd_en   = issue;
        cmd.rd_addr = POS_W'(idx_q);
        if (issue) begin
          idx_d      = idx_q + CW'(1);
          pend_d     = 1'b1;
          pend_idx_d = idx_q[AW-1:0];
        end
        if (found) begin
          res_d = '{status: STAT_OK, key: rdata_i.key, payload: rdata_i.payload,
                    position: POS_W'(pend_idx_q), last: 1'b1};
          case (act_q)
            ACT_INSERT: res_d.status = STAT_DUP;
            ACT_UPDATE: begin
              res_d.payload  = pay_q;
              cmd.wr_en      = 1'b1;
              cmd.wr_addr    = POS_W'(pend_idx_q);
              cmd.wr_key     = rdata_i.key;
              cmd.wr_payload = pay_q;
            end
            default: res_d.status = STAT_OK;
          endcase
          state_d = S_RESP;
        end else if (idx_q == count_q) begin
          if (act_q == ACT_INSERT) begin
            res_d = '{status: STAT_OK, key: key_q, payload: pay_q,
                      position: POS_W'(count_q), last: 1'b1};
            cmd.wr_en      = 1'b1;
            cmd.wr_addr    = POS_W'(count_q);
            cmd.wr_key     = key_q;
            cmd.wr_payload = pay_q;
            count_d        = count_q + CW'(1);
          end else begin
            res_d = '{status: STAT_MISS, key: '0, payload: '0, position: '0, last: 1'b1};
          end
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (out_free) begin
          push     = 1'b1;
          push_rsp = res_q;
          if (act_q == ACT_DELETE && res_q.status == STAT_OK) begin
            state_d = S_SHIFT_RD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      S_SHIFT_RD: begin
        if ((CW'(pend_idx_q) + CW'(1)) < count_q) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = POS_W'(pend_idx_q) + POS_W'(1);
          state_d     = S_SHIFT_WR;
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_IDLE;
        end
      end

      S_SHIFT_WR: begin
        cmd.wr_en      = 1'b1;
        cmd.wr_addr    = POS_W'(pend_idx_q);
        cmd.wr_key     = rdata_i.key;
        cmd.wr_payload = rdata_i.payload;
        pend_idx_d     = pend_idx_q + AW'(1);
        state_d        = S_SHIFT_RD;
      end

      S_LIST_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = POS_W'(idx_q);
        state_d     = S_LIST_EMIT;
      end

      S_LIST_EMIT: begin
        if (out_free) begin
          push     = 1'b1;
          push_rsp = '{status: STAT_OK, key: rdata_i.key, payload: rdata_i.payload,
                       position: POS_W'(idx_q), last: list_last};
          idx_d    = idx_q + CW'(1);
          state_d  = list_last ? S_IDLE : S_LIST_RD;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (push) begin
      out_vld_d = 1'b1;
      out_d     = push_rsp;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  assign cmd_o       = cmd;
  assign req_i.ready = (state_q == S_IDLE);

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.status        = out_q.status;
  assign rsp_o.found_key     = out_q.key;
  assign rsp_o.found_payload = out_q.payload;
  assign rsp_o.position      = out_q.position;
  assign rsp_o.last          = out_q.last;

endmodule
